>>> design/ckre_pkg.sv
// shared types and constants for the colour-key run extractor
`default_nettype none

package ckre_pkg;

    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned COORD_W     = 16;
    localparam int unsigned SIZE_W      = 15;
    localparam int unsigned PIXEL_W     = 16;
    localparam int unsigned OFFSET_W    = 30;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLIT_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLIT_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOR   = 3'd4;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic [SIZE_W-1:0]         blit_width;
        logic [SIZE_W-1:0]         blit_height;
        logic [PIXEL_W-1:0]        key_color;
    } t_cfg;

    // one classified event from the front, waiting for address arithmetic
    typedef struct packed {
        logic                has_run;
        logic                done;
        logic [SIZE_W-1:0]   start_col;
        logic [SIZE_W-1:0]   run_len;
        logic [SIZE_W-1:0]   row;
        logic [OFFSET_W-1:0] row_base;
    } t_run_desc;

endpackage

`default_nettype wire

>>> design/ckre_front.sv
// front end: pixel acceptance, run tracking and event classification
`default_nettype none

module ckre_front (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire ckre_pkg::t_cfg                        i_cfg,
    input  wire logic                                  i_pix_valid,
    output logic                                       o_pix_ready,
    input  wire logic [ckre_pkg::PIXEL_W-1:0]          i_pixel,
    output logic                                       o_push,
    output ckre_pkg::t_run_desc                        o_desc,
    input  wire logic                                  i_push_ready
);

    localparam int unsigned SW = ckre_pkg::SIZE_W;
    localparam int unsigned OW = ckre_pkg::OFFSET_W;

    logic [SW-1:0] r_col, n_col;
    logic [SW-1:0] r_row, n_row;
    logic          r_in_run, n_in_run;
    logic [SW-1:0] r_start, n_start;
    logic [OW-1:0] r_row_base, n_row_base;

    logic          accept;
    logic          active;
    logic          opaque;
    logic          last_col;
    logic          last_row;
    logic          emit_run;
    logic          done;
    logic [SW-1:0] start;
    logic [SW-1:0] run_end;

    assign o_pix_ready = i_push_ready;
    assign accept      = i_pix_valid && i_push_ready;
    assign active      = (i_cfg.blit_width != '0) && (i_cfg.blit_height != '0);
    assign opaque      = (i_pixel != i_cfg.key_color);
    assign last_col    = r_col >= (i_cfg.blit_width - SW'(1));
    assign last_row    = r_row >= (i_cfg.blit_height - SW'(1));
    assign done        = last_col && last_row;

    always_comb begin
        emit_run = 1'b0;
        start    = '0;
        run_end  = '0;
        if (r_in_run) begin
            start = r_start;
            if (!opaque) begin
                emit_run = 1'b1;
                run_end  = r_col;
            end else if (last_col) begin
                emit_run = 1'b1;
                run_end  = r_col + SW'(1);
            end
        end else if (opaque) begin
            start = r_col;
            if (last_col) begin
                emit_run = 1'b1;
                run_end  = r_col + SW'(1);
            end
        end
    end

    assign o_push            = accept && active && (emit_run || done);
    assign o_desc.has_run    = emit_run;
    assign o_desc.done       = done;
    assign o_desc.start_col  = start;
    assign o_desc.run_len    = run_end - start;
    assign o_desc.row        = r_row;
    assign o_desc.row_base   = r_row_base;

    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_in_run   = r_in_run;
        n_start    = r_start;
        n_row_base = r_row_base;
        if (accept && active) begin
            if (last_col) begin
                n_col    = '0;
                n_in_run = 1'b0;
                n_start  = '0;
                if (last_row) begin
                    n_row      = '0;
                    n_row_base = '0;
                end else begin
                    n_row      = r_row + SW'(1);
                    n_row_base = r_row_base + OW'(i_cfg.blit_width);
                end
            end else begin
                if (opaque && !r_in_run) begin
                    n_start = r_col;
                end
                n_in_run = opaque;
                n_col    = r_col + SW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_in_run   <= 1'b0;
            r_start    <= '0;
            r_row_base <= '0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_in_run   <= n_in_run;
            r_start    <= n_start;
            r_row_base <= n_row_base;
        end
    end

endmodule

`default_nettype wire

>>> design/ckre_queue.sv
// short descriptor queue between front and back
`default_nettype none

module ckre_queue #(
    parameter int unsigned DEPTH = ckre_pkg::QUEUE_DEPTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire ckre_pkg::t_run_desc  i_desc,
    output logic                      o_push_ready,
    output logic                      o_pop_valid,
    output ckre_pkg::t_run_desc       o_desc,
    input  wire logic                 i_pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ckre_pkg::t_run_desc r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                do_push;
    logic                do_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_desc       = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

>>> design/ckre_back.sv
// back end: destination and source address arithmetic, result register
`default_nettype none

module ckre_back (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire ckre_pkg::t_cfg                         i_cfg,
    input  wire logic                                   i_pop_valid,
    input  wire ckre_pkg::t_run_desc                    i_desc,
    output logic                                        o_pop,
    output logic                                        o_res_valid,
    input  wire logic                                   i_res_ready,
    output logic                                        o_has_run,
    output logic signed [ckre_pkg::COORD_W-1:0]         o_win_x,
    output logic signed [ckre_pkg::COORD_W-1:0]         o_win_y,
    output logic [ckre_pkg::SIZE_W-1:0]                 o_span_len,
    output logic [ckre_pkg::OFFSET_W-1:0]               o_src_offset,
    output logic                                        o_blit_done
);

    localparam int unsigned CW = ckre_pkg::COORD_W;
    localparam int unsigned SW = ckre_pkg::SIZE_W;
    localparam int unsigned OW = ckre_pkg::OFFSET_W;

    logic                 r_valid;
    logic                 r_has_run;
    logic [CW-1:0]        r_win_x;
    logic [CW-1:0]        r_win_y;
    logic [SW-1:0]        r_len;
    logic [OW-1:0]        r_src;
    logic                 r_done;
    logic [CW-1:0]        n_win_x;
    logic [CW-1:0]        n_win_y;
    logic [SW-1:0]        n_len;
    logic [OW-1:0]        n_src;

    assign o_pop = i_pop_valid && (!r_valid || i_res_ready);

    always_comb begin
        n_win_x = '0;
        n_win_y = '0;
        n_len   = '0;
        n_src   = '0;
        if (i_desc.has_run) begin
            n_win_x = CW'(i_cfg.origin_x) + CW'(i_desc.start_col);
            n_win_y = CW'(i_cfg.origin_y) + CW'(i_desc.row);
            n_len   = i_desc.run_len;
            n_src   = i_desc.row_base + OW'(i_desc.start_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_has_run <= i_desc.has_run;
            r_win_x   <= n_win_x;
            r_win_y   <= n_win_y;
            r_len     <= n_len;
            r_src     <= n_src;
            r_done    <= i_desc.done;
        end
    end

    assign o_res_valid  = r_valid;
    assign o_has_run    = r_has_run;
    assign o_win_x      = signed'(r_win_x);
    assign o_win_y      = signed'(r_win_y);
    assign o_span_len   = r_len;
    assign o_src_offset = r_src;
    assign o_blit_done  = r_done;

endmodule

`default_nettype wire

>>> design/color_key_run_extractor.sv
// top level of the colour-key run extractor: config registers, front, queue, back
// each result passes through the descriptor queue and then the back's result register before o_res_valid
// throughput: one pixel per cycle while the queue is not full, set by the run tracker in the front
// the back drains one descriptor per cycle while its result is empty or taken; the queue absorbs output stalls
// reset (i_rst_n low, synchronous) clears counters, run state, queue and config
`default_nettype none

module color_key_run_extractor #(
    parameter int unsigned QUEUE_DEPTH = ckre_pkg::QUEUE_DEPTH
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // configuration write port
    input  wire logic                                   i_cfg_we,
    input  wire logic [ckre_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [ckre_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // pixel channel
    input  wire logic                                   i_pix_valid,
    output logic                                        o_pix_ready,
    input  wire logic [ckre_pkg::PIXEL_W-1:0]           i_pixel,
    // result channel
    output logic                                        o_res_valid,
    input  wire logic                                   i_res_ready,
    output logic                                        o_has_run,
    output logic signed [ckre_pkg::COORD_W-1:0]         o_win_x,
    output logic signed [ckre_pkg::COORD_W-1:0]         o_win_y,
    output logic [ckre_pkg::SIZE_W-1:0]                 o_span_len,
    output logic [ckre_pkg::OFFSET_W-1:0]               o_src_offset,
    output logic                                        o_blit_done
);

    ckre_pkg::t_cfg      r_cfg;
    ckre_pkg::t_run_desc front_desc;
    ckre_pkg::t_run_desc queue_desc;
    logic                push;
    logic                push_ready;
    logic                pop_valid;
    logic                pop;

    // register file; the user must make writes only while the block is idle; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ckre_pkg::CFG_ORIGIN_X:    r_cfg.origin_x    <= signed'(i_cfg_data);
                ckre_pkg::CFG_ORIGIN_Y:    r_cfg.origin_y    <= signed'(i_cfg_data);
                ckre_pkg::CFG_BLIT_WIDTH:  r_cfg.blit_width  <= i_cfg_data[ckre_pkg::SIZE_W-1:0];
                ckre_pkg::CFG_BLIT_HEIGHT: r_cfg.blit_height <= i_cfg_data[ckre_pkg::SIZE_W-1:0];
                ckre_pkg::CFG_KEY_COLOR:   r_cfg.key_color   <= i_cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // front: tracks column, row and open run; emits an event on run close or rectangle end
    ckre_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_pix_valid  (i_pix_valid),
        .o_pix_ready  (o_pix_ready),
        .i_pixel      (i_pixel),
        .o_push       (push),
        .o_desc       (front_desc),
        .i_push_ready (push_ready)
    );

    // decoupling queue; pixel transfers stall only when it is full
    ckre_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_desc       (front_desc),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_desc       (queue_desc),
        .i_pop        (pop)
    );

    // back: adds origin and row base, holds the result until its transfer
    ckre_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_pop_valid  (pop_valid),
        .i_desc       (queue_desc),
        .o_pop        (pop),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_has_run    (o_has_run),
        .o_win_x      (o_win_x),
        .o_win_y      (o_win_y),
        .o_span_len   (o_span_len),
        .o_src_offset (o_src_offset),
        .o_blit_done  (o_blit_done)
    );

endmodule

`default_nettype wire

>>> design/ckre_checker.sv
// port-level checker for the colour-key run extractor, bound to the top level
`default_nettype none

module ckre_checker (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 o_res_valid,
    input wire logic                                 i_res_ready,
    input wire logic                                 o_has_run,
    input wire logic signed [ckre_pkg::COORD_W-1:0]  o_win_x,
    input wire logic signed [ckre_pkg::COORD_W-1:0]  o_win_y,
    input wire logic [ckre_pkg::SIZE_W-1:0]          o_span_len,
    input wire logic [ckre_pkg::OFFSET_W-1:0]        o_src_offset,
    input wire logic                                 o_blit_done
);

    // no result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    // a stalled result holds its valid, x position, source offset and done flag
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_win_x)
            && $stable(o_src_offset) && $stable(o_blit_done))
        else $error("stalled result changed");

    // a result without a run is only the rectangle end, with zeroed fields
    a_no_run_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_has_run |-> o_blit_done && o_win_x == '0 && o_win_y == '0
            && o_span_len == '0 && o_src_offset == '0)
        else $error("empty result not a zeroed done marker");

    // every run carries at least one pixel
    a_run_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_has_run |-> o_span_len != '0)
        else $error("run with zero length");

endmodule

bind color_key_run_extractor ckre_checker u_ckre_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_res_valid  (o_res_valid),
    .i_res_ready  (i_res_ready),
    .o_has_run    (o_has_run),
    .o_win_x      (o_win_x),
    .o_win_y      (o_win_y),
    .o_span_len   (o_span_len),
    .o_src_offset (o_src_offset),
    .o_blit_done  (o_blit_done)
);

`default_nettype wire
